### hw/rtl/rlerdct_pkg.sv
// Shared types, constants and color translation for the run-length row decoder.
package rlerdct_pkg;

	localparam int WORD_W      = 16;
	localparam int CNT_W       = 7;
	localparam int X_W         = 13;
	localparam int ORIGIN_W    = 12;
	localparam int ROW_COUNT_W = 13;
	localparam int MODE_W      = 2;
	localparam int KIND_W      = 2;
	localparam int APB_AW      = 5;
	localparam int APB_DW      = 32;
	localparam int REG_IDX_W   = 3;

	localparam int MAX_ROWS_DEF = 4096;
	localparam int CMDQ_DEPTH   = 2;

	localparam logic [X_W-1:0] X_MAX = '1;

	localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SPAN    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ROW_END = 2'd2;

	localparam logic [MODE_W-1:0] MODE_INDEX  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DITHER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CMAP   = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_COLOR_MODE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEEP_PLANES = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_X_ORIGIN    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_Y_ORIGIN    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT   = 3'd4;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LITERAL,
		PH_REPEAT
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0] op;
		logic [CNT_W-1:0]  cnt;
		logic [WORD_W-1:0] word;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0]      color_mode;
		logic                   deep_planes;
		logic [ORIGIN_W-1:0]    x_origin;
		logic                   x_origin_load;
		logic [ORIGIN_W-1:0]    y_origin;
		logic [ROW_COUNT_W-1:0] row_count;
	} cfg_t;

	function automatic logic [X_W-1:0] sat_x(input logic [X_W:0] v);
		sat_x = v[X_W] ? X_MAX : v[X_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] translate(
		input logic [MODE_W-1:0] mode,
		input logic              deep,
		input logic [WORD_W-1:0] v
	);
		logic [7:0] i;
		i = v[7:0];
		case (mode)
			MODE_DITHER: translate = deep ? {7'd0, 1'b1, i}
			                              : {10'd0, 1'b1, i[7], i[5:4], i[2:1]};
			MODE_CMAP:   translate = deep ? {8'd0, 1'b1, i[7:1]}
			                              : {11'd0, 1'b1, i[7:4]};
			default:     translate = v;
		endcase
	endfunction

endpackage

### hw/rtl/rle_row_decode_color_translate_top.sv
// Top level of the run-length row decoder with color translation.
// A result is queued when its word is accepted, then loaded into the output register.
// Throughput: one word per cycle unless stalled; nonzero-count headers give no result.
// Rate is set by the single output register, refilled from the two-entry request queue.
// Reset clears run phase, queue, output valid, x position and row index; registers
// return to their reset values (row_count 1, all others 0).
module rle_row_decode_color_translate_top #(
	parameter int MAX_ROWS = rlerdct_pkg::MAX_ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rlerdct_pkg::APB_AW-1:0]      paddr,
	input  logic [rlerdct_pkg::APB_DW-1:0]      pwdata,
	output logic [rlerdct_pkg::APB_DW-1:0]      prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rlerdct_pkg::WORD_W-1:0]      rle_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rlerdct_pkg::KIND_W-1:0]      kind,
	output logic [rlerdct_pkg::X_W-1:0]         x_first,
	output logic [rlerdct_pkg::X_W-1:0]         x_last,
	output logic [rlerdct_pkg::X_W-1:0]         row_y,
	output logic [rlerdct_pkg::WORD_W-1:0]      color,
	output logic                                image_done
);

	logic [rlerdct_pkg::MODE_W-1:0]      color_mode_q;
	logic                                deep_planes_q;
	logic [rlerdct_pkg::ORIGIN_W-1:0]    x_origin_q, y_origin_q;
	logic [rlerdct_pkg::ROW_COUNT_W-1:0] row_count_q;
	logic                                wr_en;
	logic [rlerdct_pkg::REG_IDX_W-1:0]   reg_idx;
	rlerdct_pkg::cfg_t                   cfg;
	rlerdct_pkg::cmd_t                   push_cmd, head;
	logic                                push, pop, empty, full;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[rlerdct_pkg::APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q  <= '0;
			deep_planes_q <= 1'b0;
			x_origin_q    <= '0;
			y_origin_q    <= '0;
			row_count_q   <= rlerdct_pkg::ROW_COUNT_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				rlerdct_pkg::REG_COLOR_MODE:  color_mode_q  <= pwdata[rlerdct_pkg::MODE_W-1:0];
				rlerdct_pkg::REG_DEEP_PLANES: deep_planes_q <= pwdata[0];
				rlerdct_pkg::REG_X_ORIGIN:    x_origin_q    <= pwdata[rlerdct_pkg::ORIGIN_W-1:0];
				rlerdct_pkg::REG_Y_ORIGIN:    y_origin_q    <= pwdata[rlerdct_pkg::ORIGIN_W-1:0];
				rlerdct_pkg::REG_ROW_COUNT:   row_count_q   <= pwdata[rlerdct_pkg::ROW_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rlerdct_pkg::REG_COLOR_MODE:  prdata = rlerdct_pkg::APB_DW'(color_mode_q);
			rlerdct_pkg::REG_DEEP_PLANES: prdata = rlerdct_pkg::APB_DW'(deep_planes_q);
			rlerdct_pkg::REG_X_ORIGIN:    prdata = rlerdct_pkg::APB_DW'(x_origin_q);
			rlerdct_pkg::REG_Y_ORIGIN:    prdata = rlerdct_pkg::APB_DW'(y_origin_q);
			rlerdct_pkg::REG_ROW_COUNT:   prdata = rlerdct_pkg::APB_DW'(row_count_q);
			default:                      prdata = '0;
		endcase
	end

	always_comb begin
		cfg.color_mode    = color_mode_q;
		cfg.deep_planes   = deep_planes_q;
		cfg.x_origin      = wr_en && reg_idx == rlerdct_pkg::REG_X_ORIGIN
		                    ? pwdata[rlerdct_pkg::ORIGIN_W-1:0] : x_origin_q;
		cfg.x_origin_load = wr_en && reg_idx == rlerdct_pkg::REG_X_ORIGIN;
		cfg.y_origin      = y_origin_q;
		cfg.row_count     = row_count_q;
	end

	assign in_stall = full;

	rlerdct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rle_word (rle_word),
		.push     (push),
		.cmd      (push_cmd)
	);

	rlerdct_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	rlerdct_back #(
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.x_first    (x_first),
		.x_last     (x_last),
		.row_y      (row_y),
		.color      (color),
		.image_done (image_done)
	);

endmodule

### hw/rtl/rlerdct_front.sv
// Front end: accepts encoded words, tracks run phase, issues requests to the queue.
module rlerdct_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [rlerdct_pkg::WORD_W-1:0]   rle_word,
	output logic                             push,
	output rlerdct_pkg::cmd_t                cmd
);

	rlerdct_pkg::phase_t               phase_q, phase_d;
	logic [rlerdct_pkg::CNT_W-1:0]     run_q, run_d;
	logic                              accept;
	logic [rlerdct_pkg::CNT_W-1:0]     hdr_cnt;

	assign accept  = in_valid && !in_stall;
	assign hdr_cnt = rle_word[rlerdct_pkg::CNT_W-1:0];

	always_comb begin
		phase_d = phase_q;
		run_d   = run_q;
		if (accept) begin
			case (phase_q)
				rlerdct_pkg::PH_HEADER: begin
					if (hdr_cnt != '0) begin
						run_d   = hdr_cnt;
						phase_d = rle_word[7] ? rlerdct_pkg::PH_LITERAL
						                      : rlerdct_pkg::PH_REPEAT;
					end
				end
				rlerdct_pkg::PH_LITERAL: begin
					run_d   = run_q - 1'b1;
					phase_d = (run_d == '0) ? rlerdct_pkg::PH_HEADER
					                        : rlerdct_pkg::PH_LITERAL;
				end
				rlerdct_pkg::PH_REPEAT: begin
					run_d   = '0;
					phase_d = rlerdct_pkg::PH_HEADER;
				end
				default: begin
					run_d   = '0;
					phase_d = rlerdct_pkg::PH_HEADER;
				end
			endcase
		end
	end

	always_comb begin
		push     = 1'b0;
		cmd.op   = rlerdct_pkg::KIND_ROW_END;
		cmd.cnt  = run_q;
		cmd.word = rle_word;
		case (phase_q)
			rlerdct_pkg::PH_HEADER: begin
				push   = accept && (hdr_cnt == '0);
				cmd.op = rlerdct_pkg::KIND_ROW_END;
			end
			rlerdct_pkg::PH_LITERAL: begin
				push   = accept;
				cmd.op = rlerdct_pkg::KIND_PIXEL;
			end
			rlerdct_pkg::PH_REPEAT: begin
				push   = accept;
				cmd.op = rlerdct_pkg::KIND_SPAN;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rlerdct_pkg::PH_HEADER;
			run_q   <= '0;
		end else begin
			phase_q <= phase_d;
			run_q   <= run_d;
		end
	end

endmodule

### hw/rtl/rlerdct_cmdq.sv
// Short request queue between front and back ends.
module rlerdct_cmdq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rlerdct_pkg::cmd_t push_cmd,
	input  logic              pop,
	output rlerdct_pkg::cmd_t head,
	output logic              empty,
	output logic              full
);

	localparam int DEPTH = rlerdct_pkg::CMDQ_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rlerdct_pkg::cmd_t  mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		nxt = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/rlerdct_back.sv
// Back end: positions pixels, spans and row ends, translates color, holds the output register.
module rlerdct_back #(
	parameter int MAX_ROWS = rlerdct_pkg::MAX_ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rlerdct_pkg::cfg_t                   cfg,
	input  rlerdct_pkg::cmd_t                   head,
	input  logic                                empty,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rlerdct_pkg::KIND_W-1:0]      kind,
	output logic [rlerdct_pkg::X_W-1:0]         x_first,
	output logic [rlerdct_pkg::X_W-1:0]         x_last,
	output logic [rlerdct_pkg::X_W-1:0]         row_y,
	output logic [rlerdct_pkg::WORD_W-1:0]      color,
	output logic                                image_done
);

	localparam int X_W    = rlerdct_pkg::X_W;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RC_W   = rlerdct_pkg::ROW_COUNT_W;
	localparam int CMP_W  = ((ROW_W > RC_W) ? ROW_W : RC_W) + 2;
	localparam int SUM_W  = (ROW_W > X_W) ? ROW_W : X_W;

	logic                                  out_valid_q;
	logic [rlerdct_pkg::KIND_W-1:0]        kind_q;
	logic [X_W-1:0]                        x_first_q, x_last_q, row_y_q;
	logic [rlerdct_pkg::WORD_W-1:0]        color_q;
	logic                                  done_q;
	logic [X_W-1:0]                        x_pos_q, x_pos_d;
	logic [ROW_W-1:0]                      row_q, row_d;

	logic                                  load;
	logic [rlerdct_pkg::CNT_W-1:0]         n;
	logic [X_W:0]                          sum_n, sum_nm1;
	logic [CMP_W-1:0]                      rows, row_next;
	logic                                  done_d;
	logic [X_W-1:0]                        xf_d, xl_d;
	logic [rlerdct_pkg::WORD_W-1:0]        color_d;
	logic [SUM_W-1:0]                      y_sum;

	assign load = !empty && (!out_valid_q || !out_stall);
	assign pop  = load;

	assign n       = (head.cnt == '0) ? rlerdct_pkg::CNT_W'(1) : head.cnt;
	assign sum_n   = {1'b0, x_pos_q} + (X_W + 1)'(n);
	assign sum_nm1 = sum_n - 1'b1;

	always_comb begin
		if (cfg.row_count == '0) begin
			rows = CMP_W'(1);
		end else if (CMP_W'(cfg.row_count) > CMP_W'(MAX_ROWS)) begin
			rows = CMP_W'(MAX_ROWS);
		end else begin
			rows = CMP_W'(cfg.row_count);
		end
	end

	assign row_next = CMP_W'(row_q) + 1'b1;
	assign done_d   = (row_next >= rows);
	assign y_sum    = SUM_W'(cfg.y_origin) + SUM_W'(row_q);

	always_comb begin
		xf_d    = x_pos_q;
		xl_d    = x_pos_q;
		color_d = rlerdct_pkg::translate(cfg.color_mode, cfg.deep_planes, head.word);
		x_pos_d = x_pos_q;
		row_d   = row_q;
		case (head.op)
			rlerdct_pkg::KIND_PIXEL: begin
				x_pos_d = rlerdct_pkg::sat_x({1'b0, x_pos_q} + 1'b1);
			end
			rlerdct_pkg::KIND_SPAN: begin
				xl_d    = rlerdct_pkg::sat_x(sum_nm1);
				x_pos_d = rlerdct_pkg::sat_x(sum_n);
			end
			default: begin
				color_d = '0;
				x_pos_d = X_W'(cfg.x_origin);
				row_d   = done_d ? '0 : row_next[ROW_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			x_pos_q     <= '0;
			row_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				row_q       <= row_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.x_origin_load) begin
				x_pos_q <= X_W'(cfg.x_origin);
			end else if (load) begin
				x_pos_q <= x_pos_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q    <= head.op;
			x_first_q <= xf_d;
			x_last_q  <= xl_d;
			row_y_q   <= y_sum[X_W-1:0];
			color_q   <= color_d;
			done_q    <= (head.op == rlerdct_pkg::KIND_ROW_END) && done_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign x_first    = x_first_q;
	assign x_last     = x_last_q;
	assign row_y      = row_y_q;
	assign color      = color_q;
	assign image_done = done_q;

	a_row_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == rlerdct_pkg::KIND_ROW_END
			|-> color_q == '0 && x_first_q == x_last_q)
		else $error("row end with color or span");

	a_done_only_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != rlerdct_pkg::KIND_ROW_END |-> !done_q)
		else $error("done flag on pixel or span");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == rlerdct_pkg::KIND_SPAN |-> x_last_q >= x_first_q)
		else $error("span ends before it starts");

	a_pixel_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == rlerdct_pkg::KIND_PIXEL |-> x_last_q == x_first_q)
		else $error("pixel covers more than one x");

endmodule

### dv/rle_screen_write_pkg.sv
// Screen write type and scoreboard for the run-length row decoder testbench.
package rle_screen_write_pkg;
	import rlerdct_pkg::*;

	localparam int LITERAL_FLAG = 7;
	localparam int X_TOP        = (1 << X_W) - 1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [X_W-1:0]    x_first;
		logic [X_W-1:0]    x_last;
		logic [X_W-1:0]    row_y;
		logic [WORD_W-1:0] color;
		logic              image_done;
	} screen_write_t;

	class screen_write_model;
		logic [MODE_W-1:0]      mode;
		logic                   deep;
		logic [ORIGIN_W-1:0]    x_org;
		logic [ORIGIN_W-1:0]    y_org;
		logic [ROW_COUNT_W-1:0] rows_cfg;
		phase_t                 ph;
		int                     run_left;
		int                     x_pos;
		int                     row_idx;
		screen_write_t          pending_writes[$];
		int                     fails;

		function new();
			mode     = MODE_INDEX;
			deep     = 1'b0;
			x_org    = '0;
			y_org    = '0;
			rows_cfg = 1;
			ph       = PH_HEADER;
			run_left = 0;
			x_pos    = 0;
			row_idx  = 0;
			fails    = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] data);
			case (idx)
				REG_COLOR_MODE:  mode = data[MODE_W-1:0];
				REG_DEEP_PLANES: deep = data[0];
				REG_X_ORIGIN: begin
					x_org = data[ORIGIN_W-1:0];
					x_pos = int'(data[ORIGIN_W-1:0]);
				end
				REG_Y_ORIGIN:    y_org = data[ORIGIN_W-1:0];
				REG_ROW_COUNT:   rows_cfg = data[ROW_COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		// only the low byte indexes the colormaps
		function logic [WORD_W-1:0] palette(logic [WORD_W-1:0] v);
			int i;
			i = int'(v[7:0]);
			if (mode == MODE_DITHER)
				return deep ? WORD_W'(256 + i)
				            : WORD_W'(32 + 16 * ((i >> 7) & 1) + 4 * ((i >> 4) & 3) + ((i >> 1) & 3));
			if (mode == MODE_CMAP)
				return deep ? WORD_W'(128 + (i >> 1)) : WORD_W'(16 + (i >> 4));
			return v;
		endfunction

		function int clamp_x(int v);
			return (v > X_TOP) ? X_TOP : v;
		endfunction

		function void push(logic [KIND_W-1:0] k, int xf, int xl, logic [WORD_W-1:0] c,
		                   logic done);
			screen_write_t w;
			w.kind       = k;
			w.x_first    = X_W'(xf);
			w.x_last     = X_W'(xl);
			w.row_y      = X_W'(int'(y_org) + row_idx);
			w.color      = c;
			w.image_done = done;
			pending_writes.push_back(w);
		endfunction

		function void take_word(logic [WORD_W-1:0] w);
			int  n;
			int  rows;
			bit  done;
			case (ph)
				PH_LITERAL: begin
					push(KIND_PIXEL, x_pos, x_pos, palette(w), 1'b0);
					x_pos = clamp_x(x_pos + 1);
					run_left = (run_left - 1) & ((1 << CNT_W) - 1);
					if (run_left == 0)
						ph = PH_HEADER;
				end
				PH_REPEAT: begin
					n = (run_left != 0) ? run_left : 1;
					push(KIND_SPAN, x_pos, clamp_x(x_pos + n - 1), palette(w), 1'b0);
					x_pos = clamp_x(x_pos + n);
					run_left = 0;
					ph = PH_HEADER;
				end
				default: begin
					if (w[CNT_W-1:0] == '0) begin
						rows = (rows_cfg == '0) ? 1 : int'(rows_cfg);
						if (rows > MAX_ROWS_DEF)
							rows = MAX_ROWS_DEF;
						done = (row_idx + 1 >= rows);
						push(KIND_ROW_END, x_pos, x_pos, '0, done);
						row_idx = done ? 0 : row_idx + 1;
						x_pos = int'(x_org);
						ph = PH_HEADER;
					end else begin
						run_left = int'(w[CNT_W-1:0]);
						ph = w[LITERAL_FLAG] ? PH_LITERAL : PH_REPEAT;
					end
				end
			endcase
		endfunction

		function void compare_write(screen_write_t got);
			screen_write_t want;
			if (pending_writes.size() == 0) begin
				$error("screen write with none pending: kind %0d x %0d..%0d y %0d",
				       got.kind, got.x_first, got.x_last, got.row_y);
				fails++;
				return;
			end
			want = pending_writes.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				fails++;
			end
			if (got.x_first !== want.x_first) begin
				$error("x_first: expected %0d, got %0d", want.x_first, got.x_first);
				fails++;
			end
			if (got.x_last !== want.x_last) begin
				$error("x_last: expected %0d, got %0d", want.x_last, got.x_last);
				fails++;
			end
			if (got.row_y !== want.row_y) begin
				$error("row_y: expected %0d, got %0d", want.row_y, got.row_y);
				fails++;
			end
			if (got.color !== want.color) begin
				$error("color: expected 0x%04h, got 0x%04h", want.color, got.color);
				fails++;
			end
			if (got.image_done !== want.image_done) begin
				$error("image_done: expected %0b, got %0b", want.image_done, got.image_done);
				fails++;
			end
		endfunction

		function void flag_leftovers();
			if (pending_writes.size() != 0) begin
				$error("%0d screen writes never arrived", pending_writes.size());
				fails++;
			end
		endfunction
	endclass

endpackage

### dv/rle_row_decode_color_translate_top_test.sv
// Testbench top: drives encoded words and register writes, checks every screen write.
module rle_row_decode_color_translate_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rlerdct_pkg::*;
	import rle_screen_write_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_AW-1:0]      paddr;
	logic [APB_DW-1:0]      pwdata;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;
	logic                   in_valid;
	logic                   in_stall;
	logic [WORD_W-1:0]      rle_word;
	logic                   out_valid;
	logic                   out_stall;
	logic [KIND_W-1:0]      kind;
	logic [X_W-1:0]         x_first;
	logic [X_W-1:0]         x_last;
	logic [X_W-1:0]         row_y;
	logic [WORD_W-1:0]      color;
	logic                   image_done;

	screen_write_model screen;
	int  words_sent;
	int  origin_now;
	bit  steady;
	bit  squeeze;

	rle_row_decode_color_translate_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("rle_row_decode_color_translate_top_test: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready)
				screen.set_reg(paddr[APB_AW-1:2], pwdata);
			if (in_valid && !in_stall)
				screen.take_word(rle_word);
			if (out_valid && !out_stall)
				screen.compare_write(screen_write_t'{kind, x_first, x_last, row_y, color,
				                                     image_done});
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic int pick_origin();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return (1 << ORIGIN_W) - 1;
			default: return $urandom_range(0, (1 << ORIGIN_W) - 1);
		endcase
	endfunction

	// downstream: random stalls, quiet stretches, and one long hold-off on request
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (squeeze) begin
				repeat (120) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
				squeeze = 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				repeat (30) begin
					@(negedge clk);
					out_stall <= 1'b0;
				end
			end else begin
				n = pick_gap();
				repeat (n) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
				@(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(input logic [WORD_W-1:0] w);
		int gap;
		gap = steady ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rle_word <= w;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic send_run(input bit lit, input int count);
		send_word({8'($urandom), lit, CNT_W'(count)});
		if (lit)
			repeat (count) send_word(WORD_W'($urandom));
		else
			send_word(WORD_W'($urandom));
	endtask

	// wide rows push x into saturation when the origin sits high
	task automatic send_row();
		int runs;
		bit wide;
		wide = (origin_now >= 2048) && ($urandom_range(0, 2) == 0);
		runs = wide ? 40 : $urandom_range(0, 5);
		repeat (runs) begin
			if (wide)
				send_run(1'b0, $urandom_range(100, 127));
			else
				send_run(1'($urandom_range(0, 1)), ($urandom_range(0, 9) == 0) ?
				         $urandom_range(1, 127) : $urandom_range(1, 6));
		end
		if (wide)
			send_run(1'b1, $urandom_range(1, 4));
		send_word({8'($urandom), 1'($urandom), CNT_W'(0)});
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (screen.pending_writes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic pick_settings(output int rows);
		int rc;
		int eff;
		write_reg(REG_COLOR_MODE, $urandom_range(0, 3));
		write_reg(REG_DEEP_PLANES, $urandom_range(0, 1));
		origin_now = pick_origin();
		write_reg(REG_X_ORIGIN, origin_now);
		write_reg(REG_Y_ORIGIN, pick_origin());
		case ($urandom_range(0, 9))
			0:       rc = 0;
			1:       rc = MAX_ROWS_DEF;
			2:       rc = (1 << ROW_COUNT_W) - 1;
			3:       rc = 1;
			default: rc = $urandom_range(2, 5);
		endcase
		write_reg(REG_ROW_COUNT, rc);
		eff = (rc == 0) ? 1 : ((rc > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rc);
		rows = (eff > 6) ? $urandom_range(2, 6) : eff;
	endtask

	initial begin
		int rows;
		int guard;
		screen = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		rle_word = '0;
		words_sent = 0;
		origin_now = 0;
		steady = 1'b0;
		squeeze = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: index mode, single row
		send_word(16'hFF82);
		send_word(16'h0000);
		send_word(16'hFFFF);
		send_word(16'h007F);
		send_word(16'hFFFF);
		send_word(16'h0080);
		settle();

		// dithered shallow, origins at top, row count zero
		write_reg(REG_COLOR_MODE, MODE_DITHER);
		write_reg(REG_X_ORIGIN, (1 << ORIGIN_W) - 1);
		write_reg(REG_Y_ORIGIN, (1 << ORIGIN_W) - 1);
		write_reg(REG_ROW_COUNT, 0);
		send_word(16'h0082);
		send_word(16'hAB55);
		send_word(16'h00AA);
		send_word(16'h7F01);
		send_word(16'h1234);
		send_word(16'h0000);
		settle();

		write_reg(REG_DEEP_PLANES, 1);
		send_word(16'h0081);
		send_word(16'h80FF);
		send_word(16'h0000);
		settle();

		// normal colormap, row count above the maximum
		write_reg(REG_COLOR_MODE, MODE_CMAP);
		write_reg(REG_DEEP_PLANES, 0);
		write_reg(REG_ROW_COUNT, (1 << ROW_COUNT_W) - 1);
		write_reg(REG_X_ORIGIN, 0);
		send_word(16'h0081);
		send_word(16'h00F0);
		send_word(16'h0000);
		settle();

		write_reg(REG_DEEP_PLANES, 1);
		send_word(16'h0081);
		send_word(16'h00FF);
		send_word(16'h0000);
		settle();

		write_reg(REG_COLOR_MODE, MODE_SPARE);
		send_word(16'h0081);
		send_word(16'hBEEF);
		send_word(16'h0000);

		words_sent = 0;
		steady = 1'b1;
		settle();
		// long downstream hold-off while a long literal run keeps coming
		squeeze = 1'b1;
		send_run(1'b1, 127);
		while (words_sent < 1300) begin
			settle();
			pick_settings(rows);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(3, 15)) send_word(WORD_W'($urandom));
			repeat (rows) send_row();
			steady = ($urandom_range(0, 3) == 0);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		guard = 0;
		while (screen.pending_writes.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		screen.flag_leftovers();
		if (screen.fails == 0)
			$display("rle_row_decode_color_translate_top_test: PASS");
		else
			$display("rle_row_decode_color_translate_top_test: FAIL");
		$finish;
	end

endmodule

### files.f
hw/rtl/rlerdct_pkg.sv
hw/rtl/rlerdct_front.sv
hw/rtl/rlerdct_cmdq.sv
hw/rtl/rlerdct_back.sv
hw/rtl/rle_row_decode_color_translate_top.sv
dv/rle_screen_write_pkg.sv
dv/rle_row_decode_color_translate_top_test.sv
